[design/round_barrier_message_gate_macros.svh]
// Assertion macros used by the round barrier message gate sequencer.
// Each macro expects signals named clk and rst in the scope that uses it.
`ifndef ROUND_BARRIER_MESSAGE_GATE_MACROS_SVH
`define ROUND_BARRIER_MESSAGE_GATE_MACROS_SVH

// Same-cycle implication.
`define RBMG_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define RBMG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/rbmg_pkg.sv]
// Types and codes shared by the round barrier message gate modules.
// No dependencies.
package rbmg_pkg;

  typedef struct packed {
    logic [15:0] payload;
    logic        barrier;
    logic [1:0]  round;
    logic [15:0] dest;
    logic [15:0] sender;
  } msg_t;

  localparam int MSG_W = $bits(msg_t);

  typedef enum logic [1:0] {
    KIND_DATA    = 2'd0,
    KIND_BARRIER = 2'd1,
    KIND_DROP    = 2'd2
  } kind_t;

  typedef struct packed {
    msg_t  msg;
    kind_t kind;
    logic  last;
  } res_t;

endpackage

[design/rbmg_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbmg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[design/rbmg_seq.sv]
// Sequencer of the round barrier message gate: per-PE counter RAM, hold FIFO RAM,
// completion scan and replay. Depends on rbmg_pkg, rbmg_ram and the macro header.
`include "round_barrier_message_gate_macros.svh"

module rbmg_seq
  import rbmg_pkg::*;
#(
  parameter int NUM_PE     = 16,
  parameter int NUM_ROUNDS = 4,
  parameter int PE_SHIFT   = 12,
  parameter int HOLD_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  msg_t       in_msg,
  input  logic [3:0] own_pe_id,
  input  logic       out_free,
  output logic       res_load,
  output res_t       res
);
  localparam int PW  = NUM_PE > 1 ? $clog2(NUM_PE) : 1;
  localparam int AW  = HOLD_DEPTH > 1 ? $clog2(HOLD_DEPTH) : 1;
  localparam int HCW = $clog2(HOLD_DEPTH + 1);
  localparam int RW  = NUM_ROUNDS > 1 ? $clog2(NUM_ROUNDS) : 1;
  localparam int CW  = RW > 2 ? RW : 2;

  typedef enum logic [3:0] {
    S_IDLE, S_DROP, S_CWAIT, S_CUPD, S_SCAN_W, S_SCAN_C, S_EMITD,
    S_PRE, S_CNT_R, S_CNT_C, S_EMITB, S_RP_R, S_RP_C, S_RP_W, S_RP_U
  } state_t;

  state_t          state;
  msg_t            m;
  logic [PW-1:0]   cidx;
  logic            pe_ok_q;
  logic            done;
  logic [RW-1:0]   cur_round;
  logic [RW-1:0]   nround;
  logic [HCW-1:0]  held_count;
  logic [HCW-1:0]  fidx;
  logic [HCW-1:0]  keep;
  logic [HCW-1:0]  match_cnt;
  logic [NUM_PE-1:0] seen;
  logic [NUM_PE-1:0] vld;

  logic            accept;
  logic [15:0]     in_pe;
  logic            in_pe_ok;
  logic            in_match;
  logic            room;
  msg_t            f_msg;
  logic [15:0]     f_pe;
  logic            f_pe_ok;
  logic            f_match_new;
  logic            f_match_cur;
  logic            f_we;
  logic [AW-1:0]   f_waddr;
  msg_t            f_wdata;
  logic [MSG_W-1:0] f_rdata;
  logic            c_we;
  logic [31:0]     c_wdata;
  logic [31:0]     c_rdata;
  logic [15:0]     cur_exp;
  logic [15:0]     cur_recv;
  logic [15:0]     recv_inc;
  logic            scan_ok;

  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign in_pe       = in_msg.sender >> PE_SHIFT;
  assign in_pe_ok    = in_pe < 16'(NUM_PE);
  assign in_match    = CW'(in_msg.round) == CW'(cur_round);
  assign room        = held_count < HCW'(HOLD_DEPTH);
  assign nround      = (cur_round == RW'(NUM_ROUNDS - 1)) ? '0 : cur_round + 1'b1;

  assign f_msg       = msg_t'(f_rdata);
  assign f_pe        = f_msg.sender >> PE_SHIFT;
  assign f_pe_ok     = f_pe < 16'(NUM_PE);
  assign f_match_new = CW'(f_msg.round) == CW'(nround);
  assign f_match_cur = CW'(f_msg.round) == CW'(cur_round);

  assign cur_exp     = vld[cidx] ? c_rdata[31:16] : 16'd0;
  assign cur_recv    = vld[cidx] ? c_rdata[15:0] : 16'd0;
  assign recv_inc    = (&cur_recv) ? cur_recv : cur_recv + 16'd1;
  assign scan_ok     = seen[cidx] && (cur_exp == cur_recv);

  always_comb begin
    f_we    = 1'b0;
    f_waddr = held_count[AW-1:0];
    f_wdata = in_msg;
    if (accept && !in_match && room) begin
      f_we = 1'b1;
    end else if (state == S_RP_C && !f_match_cur) begin
      f_we    = 1'b1;
      f_waddr = keep[AW-1:0];
      f_wdata = f_msg;
    end
  end

  assign c_we    = pe_ok_q && ((state == S_CUPD) || (state == S_RP_U && out_free));
  assign c_wdata = (state == S_CUPD && m.barrier) ? {m.dest, cur_recv} : {cur_exp, recv_inc};

  always_comb begin
    res.msg  = m;
    res.kind = KIND_DATA;
    res.last = 1'b1;
    unique case (state)
      S_DROP: res.kind = KIND_DROP;
      S_EMITD: res.last = !done;
      S_EMITB: begin
        res.msg.sender  = 16'({12'd0, own_pe_id} << PE_SHIFT);
        res.msg.dest    = 16'd0;
        res.msg.round   = 2'(cur_round);
        res.msg.barrier = 1'b1;
        res.msg.payload = 16'd0;
        res.kind        = KIND_BARRIER;
        res.last        = (match_cnt == '0);
      end
      S_RP_U: res.last = (match_cnt == HCW'(1));
      default: res.kind = KIND_DATA;
    endcase
  end

  assign res_load = out_free && (state == S_DROP || state == S_EMITD ||
                                 state == S_EMITB || state == S_RP_U);

  rbmg_ram #(.WIDTH(32), .DEPTH(NUM_PE)) u_cnt_ram (
    .clk(clk), .we(c_we), .waddr(cidx), .wdata(c_wdata), .raddr(cidx), .rdata(c_rdata)
  );

  rbmg_ram #(.WIDTH(MSG_W), .DEPTH(HOLD_DEPTH)) u_hold_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata), .raddr(fidx[AW-1:0]),
    .rdata(f_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      cur_round  <= '0;
      held_count <= '0;
      seen       <= '0;
      vld        <= '0;
      fidx       <= '0;
      keep       <= '0;
      match_cnt  <= '0;
      cidx       <= '0;
      pe_ok_q    <= 1'b0;
      done       <= 1'b0;
    end else begin
      if (c_we) begin
        vld[cidx] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            m <= in_msg;
            if (!in_match) begin
              if (room) begin
                held_count <= held_count + 1'b1;
              end else begin
                state <= S_DROP;
              end
            end else begin
              cidx    <= in_pe[PW-1:0];
              pe_ok_q <= in_pe_ok;
              state   <= S_CWAIT;
            end
          end
        end
        S_DROP: if (out_free) state <= S_IDLE;
        S_CWAIT: state <= S_CUPD;
        S_CUPD: begin
          if (pe_ok_q && m.barrier) begin
            seen[cidx] <= 1'b1;
          end
          cidx  <= '0;
          state <= S_SCAN_W;
        end
        S_SCAN_W: state <= S_SCAN_C;
        S_SCAN_C: begin
          if (!scan_ok) begin
            done  <= 1'b0;
            state <= m.barrier ? S_IDLE : S_EMITD;
          end else if (cidx == PW'(NUM_PE - 1)) begin
            done  <= 1'b1;
            state <= m.barrier ? S_PRE : S_EMITD;
          end else begin
            cidx  <= cidx + 1'b1;
            state <= S_SCAN_W;
          end
        end
        S_EMITD: if (out_free) state <= done ? S_PRE : S_IDLE;
        S_PRE: begin
          fidx      <= '0;
          match_cnt <= '0;
          state     <= S_CNT_R;
        end
        S_CNT_R: state <= (fidx == held_count) ? S_EMITB : S_CNT_C;
        S_CNT_C: begin
          if (f_match_new) begin
            match_cnt <= match_cnt + 1'b1;
          end
          fidx  <= fidx + 1'b1;
          state <= S_CNT_R;
        end
        S_EMITB: begin
          if (out_free) begin
            cur_round <= nround;
            seen      <= '0;
            vld       <= '0;
            fidx      <= '0;
            keep      <= '0;
            state     <= S_RP_R;
          end
        end
        S_RP_R: begin
          if (fidx == held_count) begin
            held_count <= keep;
            state      <= S_IDLE;
          end else begin
            state <= S_RP_C;
          end
        end
        S_RP_C: begin
          if (f_match_cur) begin
            m       <= f_msg;
            cidx    <= f_pe[PW-1:0];
            pe_ok_q <= f_pe_ok;
            state   <= S_RP_W;
          end else begin
            keep  <= keep + 1'b1;
            fidx  <= fidx + 1'b1;
            state <= S_RP_R;
          end
        end
        S_RP_W: state <= S_RP_U;
        S_RP_U: begin
          if (out_free) begin
            match_cnt <= match_cnt - 1'b1;
            fidx      <= fidx + 1'b1;
            state     <= S_RP_R;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RBMG_ASSERT_IMP(a_hold_bound, 1'b1, held_count <= HCW'(HOLD_DEPTH), "hold count overflow")
  `RBMG_ASSERT_IMP(a_load_free, res_load, out_free, "result loaded into a full output")
  `RBMG_ASSERT_NEXT(a_round_adv, state == S_EMITB && out_free, cur_round != $past(cur_round), "round did not advance")
  `RBMG_ASSERT_IMP(a_keep_order, state == S_RP_R || state == S_RP_C, keep <= fidx, "compaction overtook the read pointer")
endmodule

[design/round_barrier_message_gate.sv]
// Top level of the round barrier message gate: APB register, stream ports, output register.
// Depends on rbmg_pkg and rbmg_seq.
//
// Messages enter on the s_axis channel and results leave on the m_axis channel.
// A message of another round is written into the hold FIFO as it is taken and gives no beat.
// If the FIFO is full it comes back on m_axis with kind dropped.
// A message of the current round updates its PE's counters, and the completion scan then
// reads the per-PE counter RAM one PE after another and stops at the first PE that is not
// complete; a data message then gives its data beat.
// On completion the block emits its own barrier after a pass over the hold FIFO that
// counts the held messages of the new round, then replays those messages and keeps the
// others, compacted, in the FIFO.
// One message is worked on at a time; s_axis_tready is high only while idle.
// Results sit in an output register; while the receiver stalls, the sequencer waits.
// Reset clears the round, the counters and the FIFO fill; own_pe_id returns to zero.
module round_barrier_message_gate
  import rbmg_pkg::*;
#(
  parameter int NUM_PE     = 16,
  parameter int NUM_ROUNDS = 4,
  parameter int PE_SHIFT   = 12,
  parameter int HOLD_DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // sender[15:0], dest[31:16], round[33:32], payload[49:34], zero fill
  input  logic [55:0] s_axis_tdata,
  // is_barrier[0]
  input  logic        s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // out_sender[15:0], out_dest[31:16], out_round[33:32], out_payload[49:34], zero fill
  output logic [55:0] m_axis_tdata,
  // out_barrier[0], kind[2:1]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [3:0] own_pe_id;
  msg_t       in_msg;
  res_t       res;
  res_t       out_res;
  logic       res_load;
  logic       out_free;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {28'd0, own_pe_id} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      own_pe_id <= 4'd0;
    end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
      own_pe_id <= pwdata[3:0];
    end
  end

  assign in_msg.sender  = s_axis_tdata[15:0];
  assign in_msg.dest    = s_axis_tdata[31:16];
  assign in_msg.round   = s_axis_tdata[33:32];
  assign in_msg.payload = s_axis_tdata[49:34];
  assign in_msg.barrier = s_axis_tuser;

  assign out_free = !m_axis_tvalid || m_axis_tready;

  rbmg_seq #(
    .NUM_PE(NUM_PE), .NUM_ROUNDS(NUM_ROUNDS), .PE_SHIFT(PE_SHIFT), .HOLD_DEPTH(HOLD_DEPTH)
  ) u_seq (
    .clk(clk), .rst(rst), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_msg(in_msg), .own_pe_id(own_pe_id), .out_free(out_free),
    .res_load(res_load), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res <= res;
    end
  end

  assign m_axis_tdata = {6'd0, out_res.msg.payload, out_res.msg.round,
                         out_res.msg.dest, out_res.msg.sender};
  assign m_axis_tuser = {out_res.kind, out_res.msg.barrier};
  assign m_axis_tlast = out_res.last;
endmodule
